>>> sv/btl_pkg.sv
// btl_pkg: shared types and constants for the blob track label table
// no dependencies
package btl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_EOF    = 1'b1;

  localparam logic REG_MIN_AGE = 1'b0;
  localparam logic REG_MAX_AGE = 1'b1;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [10:0] width;
    logic [10:0] height;
  } geo_t;

  typedef struct packed {
    logic [15:0] label;
    geo_t        geo;
    logic [7:0]  age;
  } entry_t;

  typedef struct packed {
    logic        command;
    logic [10:0] det_row;
    logic [10:0] det_col;
    logic [10:0] det_width;
    logic [10:0] det_height;
  } in_word_t;

  typedef struct packed {
    logic [15:0] label;
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic [10:0] out_width;
    logic [10:0] out_height;
    logic [7:0]  out_age;
    logic        carried;
    logic        valid_res;
    logic        overflow;
    logic        last;
  } out_word_t;

endpackage

>>> sv/btl_cell.sv
// btl_cell: one slot of the old track table, part of a rotating chain
// depends on btl_pkg
module btl_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic            load_i,
  input  btl_pkg::entry_t entry_i,
  input  logic            matched_i,
  input  btl_pkg::entry_t load_entry_i,
  output btl_pkg::entry_t entry_o,
  output logic            matched_o
);
  import btl_pkg::*;

  entry_t entry_q;
  logic   matched_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= load_entry_i;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= 1'b0;
    end else if (load_i) begin
      matched_q <= 1'b0;
    end else if (shift_i) begin
      matched_q <= matched_i;
    end
  end

  assign entry_o   = entry_q;
  assign matched_o = matched_q;

endmodule

>>> sv/btl_match.sv
// btl_match: mutual half-extent overlap test of a track and a detection
// depends on btl_pkg
module btl_match (
  input  btl_pkg::geo_t trk_i,
  input  btl_pkg::geo_t det_i,
  output logic          hit_o
);
  import btl_pkg::*;

  logic [11:0] ar, ac, br, bc, ahh, awh, bhh, bwh;
  logic        b_in_a, a_in_b;

  always_comb begin
    ar  = {1'b0, trk_i.row};
    ac  = {1'b0, trk_i.col};
    br  = {1'b0, det_i.row};
    bc  = {1'b0, det_i.col};
    ahh = {2'b00, trk_i.height[10:1]};
    awh = {2'b00, trk_i.width[10:1]};
    bhh = {2'b00, det_i.height[10:1]};
    bwh = {2'b00, det_i.width[10:1]};
    // a - h < b < a + h, rearranged to stay unsigned
    b_in_a = (ar < br + ahh) && (br < ar + ahh) && (ac < bc + awh) && (bc < ac + awh);
    a_in_b = (br < ar + bhh) && (ar < br + bhh) && (bc < ac + bwh) && (ac < bc + bwh);
    hit_o  = b_in_a || a_in_b;
  end

endmodule

>>> sv/blob_track_label_table_unit.sv
// blob_track_label_table_unit: frame-to-frame blob tracker, top level
// depends on btl_pkg, btl_cell, btl_match
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_ready_o     btl_pkg::in_word_t
//   out       output     out_valid_o / out_ready_i   btl_pkg::out_word_t
//   cfg       input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// every word walks the old table as it rotates once through the cell chain,
// one cell per cycle while the rotation is not stalled, then passes a hand-off
// state and an idle state; a new word is taken only once the last is through.
// a detection result is registered for the out channel in the hand-off state.
// end of frame stalls the rotation while a carried result cannot move on.
// reset empties both tables and sets the next label to one; no clearing pass.
module blob_track_label_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  btl_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btl_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import btl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DET  = 2'd1;
  localparam logic [1:0] ST_EOF  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             cmd_q;
  geo_t             det_q;
  logic [IDX_W-1:0] step_q;
  logic [7:0]       min_age_q, max_age_q;
  logic [CNT_W-1:0] old_cnt_q, new_cnt_q;
  logic [15:0]      next_label_q;
  logic             found_q;
  logic [15:0]      lab_q;
  logic [7:0]       age_q;
  logic [RES_W-1:0] n_q;
  out_word_t        stage_q;
  logic             stage_v_q;
  out_word_t        out_q;
  logic             out_v_q;

  entry_t           new_tab [TABLE_DEPTH];
  entry_t           cell_out [TABLE_DEPTH];
  logic             cell_m [TABLE_DEPTH];

  entry_t           head, proc_entry;
  logic             proc_m, hit, head_v, cand, emit_ok, out_free, can_step;
  logic             shift, load, out_load, store, new_full;
  out_word_t        out_d, carry_w, det_w;
  entry_t           store_e;
  logic [8:0]       age_inc;

  assign head = cell_out[0];

  btl_match u_match (
    .trk_i (head.geo),
    .det_i (det_q),
    .hit_o (hit)
  );

  always_comb begin
    head_v   = {1'b0, step_q} < old_cnt_q;
    age_inc  = {1'b0, head.age} + 9'd1;
    new_full = new_cnt_q >= CNT_W'(TABLE_DEPTH);
    out_free = !out_v_q || out_ready_i;
    cand     = head_v && !cell_m[0] && (age_inc <= {1'b0, max_age_q});
    emit_ok  = cand && (n_q < RES_W'(MAX_RESULTS));

    proc_entry = head;
    proc_m     = cell_m[0];
    if (state_q == ST_DET && head_v && hit) begin
      proc_m = 1'b1;
      if (head.age < min_age_q) begin
        proc_entry.age = head.age + 8'd1;
      end
    end

    carry_w = '{label: head.label, out_row: head.geo.row, out_col: head.geo.col,
                out_width: head.geo.width, out_height: head.geo.height,
                out_age: age_inc[7:0], carried: 1'b1, valid_res: 1'b1,
                overflow: new_full, last: 1'b0};
    det_w   = '{label: found_q ? lab_q : next_label_q, out_row: det_q.row,
                out_col: det_q.col, out_width: det_q.width, out_height: det_q.height,
                out_age: age_q, carried: 1'b0, valid_res: 1'b1,
                overflow: new_full, last: 1'b1};

    can_step = 1'b1;
    shift    = 1'b0;
    load     = 1'b0;
    out_load = 1'b0;
    out_d    = stage_q;
    store    = 1'b0;
    store_e  = '{label: head.label, geo: head.geo, age: age_inc[7:0]};
    state_d  = state_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_word_i.command == CMD_EOF) ? ST_EOF : ST_DET;
        end
      end
      ST_DET: begin
        shift = 1'b1;
        if (step_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_EOF: begin
        can_step = !(emit_ok && stage_v_q && !out_free);
        if (can_step) begin
          shift = 1'b1;
          store = cand;
          if (emit_ok && stage_v_q) begin
            out_load = 1'b1;
          end
          if (step_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (cmd_q == CMD_DETECT) begin
            out_d   = det_w;
            store   = 1'b1;
            store_e = '{label: det_w.label, geo: det_q, age: age_q};
          end else begin
            load = 1'b1;
            if (stage_v_q) begin
              out_d      = stage_q;
              out_d.last = 1'b1;
            end else begin
              out_d = '{label: 16'd0, out_row: 11'd0, out_col: 11'd0, out_width: 11'd0,
                        out_height: 11'd0, out_age: 8'd0, carried: 1'b0,
                        valid_res: 1'b0, overflow: 1'b0, last: 1'b1};
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nb_e;
    logic   nb_m;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign nb_e = proc_entry;
      assign nb_m = proc_m;
    end else begin : g_mid
      assign nb_e = cell_out[k+1];
      assign nb_m = cell_m[k+1];
    end
    btl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (shift),
      .load_i       (load),
      .entry_i      (nb_e),
      .matched_i    (nb_m),
      .load_entry_i (new_tab[k]),
      .entry_o      (cell_out[k]),
      .matched_o    (cell_m[k])
    );
  end

  // new table is written in arrival order at the fill count
  always_ff @(posedge clk_i) begin
    if (store && !new_full) begin
      new_tab[new_cnt_q[IDX_W-1:0]] <= store_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      det_q <= '{row: in_word_i.det_row, col: in_word_i.det_col,
                 width: in_word_i.det_width, height: in_word_i.det_height};
      cmd_q <= in_word_i.command;
    end
    if (state_q == ST_EOF && can_step && emit_ok) begin
      stage_q <= carry_w;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      min_age_q    <= 8'd0;
      max_age_q    <= 8'd0;
      old_cnt_q    <= '0;
      new_cnt_q    <= '0;
      next_label_q <= 16'd1;
      found_q      <= 1'b0;
      lab_q        <= 16'd0;
      age_q        <= 8'd0;
      n_q          <= '0;
      stage_v_q    <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_AGE) begin
          min_age_q <= cfg_data_i;
        end else begin
          max_age_q <= cfg_data_i;
        end
      end
      if (state_q == ST_IDLE) begin
        step_q    <= '0;
        found_q   <= 1'b0;
        lab_q     <= 16'd0;
        age_q     <= 8'd0;
        n_q       <= '0;
        stage_v_q <= 1'b0;
      end
      if (shift) begin
        step_q <= step_q + IDX_W'(1);
      end
      if (state_q == ST_DET && head_v && hit) begin
        found_q <= 1'b1;
        lab_q   <= head.label;
        if (head.age < min_age_q && age_q < proc_entry.age) begin
          age_q <= proc_entry.age;
        end
      end
      if (state_q == ST_EOF && can_step && emit_ok) begin
        stage_v_q <= 1'b1;
        n_q       <= n_q + RES_W'(1);
      end
      if (store && !new_full) begin
        new_cnt_q <= new_cnt_q + CNT_W'(1);
      end
      if (state_q == ST_DONE && out_free && cmd_q == CMD_DETECT && !found_q) begin
        next_label_q <= next_label_q + 16'd1;
      end
      if (load) begin
        old_cnt_q <= (store && !new_full) ? new_cnt_q + CNT_W'(1) : new_cnt_q;
        new_cnt_q <= '0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

>>> tb/btl_checker.sv
// btl_checker: predicts the tracker's result words and compares them on the out channel
// depends on btl_pkg; watches the in, out and cfg ports of blob_track_label_table_unit
`timescale 1ns / 100ps
module btl_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  btl_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  btl_pkg::out_word_t out_word_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 seen_o,
  output int                 carried_seen_o,
  output int                 overflow_seen_o,
  output int                 match_seen_o
);
  import btl_pkg::*;

  entry_t    old_tab [TABLE_DEPTH];
  entry_t    new_tab [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] old_hit;
  int        old_n, new_n;
  logic [15:0] next_lab;
  logic [15:0] before_lab;
  logic [7:0]  min_age_q, max_age_q;
  out_word_t track_q[$];

  assign pending_o = track_q.size();

  function automatic bit inside_half(geo_t a, geo_t b);
    int ar, ac, aw, ah, br, bc;
    ar = int'(a.row); ac = int'(a.col); aw = int'(a.width); ah = int'(a.height);
    br = int'(b.row); bc = int'(b.col);
    return (ar - ah / 2 < br) && (br < ar + ah / 2) &&
           (ac - aw / 2 < bc) && (bc < ac + aw / 2);
  endfunction

  function automatic out_word_t make_word(logic [15:0] lab, geo_t g, logic [7:0] age,
                                          logic car, logic vld, logic ovf);
    out_word_t w;
    w.label = lab;      w.out_row = g.row;       w.out_col = g.col;
    w.out_width = g.width; w.out_height = g.height; w.out_age = age;
    w.carried = car;    w.valid_res = vld;       w.overflow = ovf;
    w.last = 1'b0;
    return w;
  endfunction

  // stores into the new table; returns 1 when the table was already full
  function automatic logic store_track(logic [15:0] lab, geo_t g, logic [7:0] age);
    if (new_n >= TABLE_DEPTH) return 1'b1;
    new_tab[new_n].label = lab;
    new_tab[new_n].geo   = g;
    new_tab[new_n].age   = age;
    new_n++;
    return 1'b0;
  endfunction

  task automatic track_word(in_word_t w);
    geo_t        g;
    logic        found, ovf;
    logic [15:0] lab;
    logic [7:0]  age;
    logic [8:0]  a;
    out_word_t   r;
    int          n;
    g.row = w.det_row; g.col = w.det_col; g.width = w.det_width; g.height = w.det_height;
    if (w.command == CMD_DETECT) begin
      found = 1'b0; lab = '0; age = '0;
      for (int i = 0; i < old_n; i++) begin
        if (inside_half(old_tab[i].geo, g) || inside_half(g, old_tab[i].geo)) begin
          found = 1'b1;
          old_hit[i] = 1'b1;
          lab = old_tab[i].label;
          if (old_tab[i].age < min_age_q) begin
            old_tab[i].age = old_tab[i].age + 8'd1;
            if (age < old_tab[i].age) age = old_tab[i].age;
          end
        end
      end
      if (!found) begin
        lab = next_lab;
        next_lab = next_lab + 16'd1;
      end
      ovf = store_track(lab, g, age);
      r = make_word(lab, g, age, 1'b0, 1'b1, ovf);
      r.last = 1'b1;
      track_q = {track_q, r};
    end else begin
      n = 0;
      for (int i = 0; i < old_n; i++) begin
        a = {1'b0, old_tab[i].age} + 9'd1;
        if (!old_hit[i] && a <= {1'b0, max_age_q}) begin
          ovf = store_track(old_tab[i].label, old_tab[i].geo, a[7:0]);
          if (n < MAX_RESULTS) begin
            r = make_word(old_tab[i].label, old_tab[i].geo, a[7:0], 1'b1, 1'b1, ovf);
            r.last = 1'b0;
            track_q = {track_q, r};
            n++;
          end
        end
      end
      if (n == 0) begin
        r = '0;
        track_q = {track_q, r};
      end
      track_q[track_q.size() - 1].last = 1'b1;
      for (int i = 0; i < new_n; i++) old_tab[i] = new_tab[i];
      old_n = new_n;
      new_n = 0;
      old_hit = '0;
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t exp_w;
    if (track_q.size() == 0) begin
      $error("result word with nothing expected: %p", got);
      fail_count_o++;
      return;
    end
    exp_w = track_q.pop_front();
    if (got.label !== exp_w.label) begin
      $error("label: expected %0d got %0d", exp_w.label, got.label); fail_count_o++;
    end
    if (got.out_row !== exp_w.out_row) begin
      $error("out_row: expected %0d got %0d", exp_w.out_row, got.out_row); fail_count_o++;
    end
    if (got.out_col !== exp_w.out_col) begin
      $error("out_col: expected %0d got %0d", exp_w.out_col, got.out_col); fail_count_o++;
    end
    if (got.out_width !== exp_w.out_width) begin
      $error("out_width: expected %0d got %0d", exp_w.out_width, got.out_width);
      fail_count_o++;
    end
    if (got.out_height !== exp_w.out_height) begin
      $error("out_height: expected %0d got %0d", exp_w.out_height, got.out_height);
      fail_count_o++;
    end
    if (got.out_age !== exp_w.out_age) begin
      $error("out_age: expected %0d got %0d", exp_w.out_age, got.out_age); fail_count_o++;
    end
    if (got.carried !== exp_w.carried) begin
      $error("carried: expected %0d got %0d", exp_w.carried, got.carried); fail_count_o++;
    end
    if (got.valid_res !== exp_w.valid_res) begin
      $error("valid_res: expected %0d got %0d", exp_w.valid_res, got.valid_res);
      fail_count_o++;
    end
    if (got.overflow !== exp_w.overflow) begin
      $error("overflow: expected %0d got %0d", exp_w.overflow, got.overflow);
      fail_count_o++;
    end
    if (got.last !== exp_w.last) begin
      $error("last: expected %0d got %0d", exp_w.last, got.last); fail_count_o++;
    end
    seen_o++;
    if (exp_w.carried) carried_seen_o++;
    if (exp_w.overflow) overflow_seen_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_hit = '0;
      old_n = 0; new_n = 0;
      next_lab = 16'd1;
      before_lab = 16'd1;
      min_age_q = '0; max_age_q = '0;
      fail_count_o = 0; seen_o = 0;
      carried_seen_o = 0; overflow_seen_o = 0; match_seen_o = 0;
      track_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_AGE) min_age_q = cfg_data_i;
        else max_age_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) check_word(out_word_i);
      if (in_valid_i && in_ready_i) begin
        before_lab = next_lab;
        track_word(in_word_i);
        if (in_word_i.command == CMD_DETECT && next_lab == before_lab) match_seen_o++;
      end
    end
  end
endmodule

>>> tb/testbench.sv
// testbench: stimulus and verdict for blob_track_label_table_unit
// depends on btl_pkg, btl_checker and the tracker rtl
`timescale 1ns / 100ps
module testbench;
  import btl_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_idx = REG_MIN_AGE;
  logic [7:0] cfg_data = '0;

  int fail_count, pending, seen, carried_seen, overflow_seen, match_seen;
  int items_sent = 0;
  int cycles = 0;
  int phase = 0;
  int hold_left = 0;
  bit held = 0;
  geo_t prev_blobs[$];
  geo_t cur_blobs[$];

  localparam int CYCLE_LIMIT = 2000000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  blob_track_label_table_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  btl_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_word_i(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .seen_o(seen),
    .carried_seen_o(carried_seen), .overflow_seen_o(overflow_seen),
    .match_seen_o(match_seen)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (!held && items_sent >= 150) begin
      held = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (phase == 2) begin
      out_ready <= ($urandom_range(99) >= 57);
    end else if (phase == 3) begin
      out_ready <= ($urandom_range(99) >= 30);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_word  <= w;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    phase = (items_sent / 70) % 4;
    gap = 0;
    if ((phase == 1 && $urandom_range(99) < 57) || (phase == 3 && $urandom_range(99) < 30))
      gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_blob(int r, int c, int w, int h);
    in_word_t x;
    geo_t g;
    x.command = CMD_DETECT;
    x.det_row = 11'(r); x.det_col = 11'(c); x.det_width = 11'(w); x.det_height = 11'(h);
    g.row = 11'(r); g.col = 11'(c); g.width = 11'(w); g.height = 11'(h);
    cur_blobs = {cur_blobs, g};
    send_word(x);
  endtask

  task automatic send_frame_end();
    in_word_t x;
    x = '0;
    x.command = CMD_EOF;
    x.det_row = 11'($urandom); x.det_col = 11'($urandom);
    x.det_width = 11'($urandom); x.det_height = 11'($urandom);
    send_word(x);
    prev_blobs = cur_blobs;
    cur_blobs.delete();
  endtask

  // registers change only once the block has drained
  task automatic write_regs(logic [7:0] lo_age, logic [7:0] hi_age);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= REG_MIN_AGE; cfg_data <= lo_age;
    @(posedge clk_i);
    cfg_idx <= REG_MAX_AGE; cfg_data <= hi_age;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int jitter(int v, int span);
    int r;
    r = v + $urandom_range(2 * span) - span;
    if (r < 0) r = 0;
    if (r > 2047) r = 2047;
    return r;
  endfunction

  initial begin
    int nblobs, frame_no;
    geo_t p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, matching, carry-over, empty frame end, table full
    write_regs(8'd2, 8'd3);
    send_blob(0, 0, 0, 0);
    send_blob(2047, 2047, 2047, 2047);
    send_blob(100, 100, 20, 20);
    send_blob(1500, 300, 8, 40);
    send_frame_end();
    send_blob(102, 101, 4, 4);
    send_blob(1500, 300, 8, 40);
    send_blob(1518, 302, 2, 2);
    send_frame_end();
    send_frame_end();
    send_frame_end();
    send_frame_end();
    send_frame_end();
    for (int i = 0; i < 17; i++) send_blob($urandom, $urandom, $urandom, $urandom);
    send_frame_end();
    write_regs(8'd255, 8'd255);
    send_frame_end();
    send_frame_end();

    frame_no = 0;
    while (items_sent < 272) begin
      frame_no++;
      if (frame_no % 6 == 0) begin
        case ((frame_no / 6) % 4)
          0: write_regs(8'd0, 8'd0);
          1: write_regs(8'd255, 8'd255);
          2: write_regs(8'd1, 8'd2);
          default: write_regs(8'($urandom), 8'($urandom));
        endcase
      end
      nblobs = ($urandom_range(9) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 6);
      for (int i = 0; i < nblobs; i++) begin
        if (prev_blobs.size() > 0 && $urandom_range(99) < 65) begin
          p = prev_blobs[$urandom_range(prev_blobs.size() - 1)];
          send_blob(jitter(int'(p.row), 4), jitter(int'(p.col), 4),
                    jitter(int'(p.width), 6), jitter(int'(p.height), 6));
        end else if ($urandom_range(9) == 0) begin
          send_blob($urandom, $urandom, $urandom, $urandom);
        end else begin
          send_blob($urandom_range(2047), $urandom_range(2047),
                    $urandom_range(8, 120), $urandom_range(8, 120));
        end
      end
      send_frame_end();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d input words, %0d result words (%0d carried, %0d overflow)",
             items_sent, seen, carried_seen, overflow_seen);
    $display("%0d detections took an existing label", match_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fail_count, pending);
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/btl_pkg.sv
sv/btl_cell.sv
sv/btl_match.sv
sv/blob_track_label_table_unit.sv
tb/btl_checker.sv
tb/testbench.sv
